// ===== rtl/sha2h_pkg.sv =====
package sha2h_pkg;

    localparam int LENGTH_LIMIT_BITS_DEF = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int BLOCK_BITS = 512;
    localparam int ROUND_COUNT = 64;

    localparam logic REG_HASH_MODE = 1'b0;
    localparam logic [7:0] PAD_MARKER = 8'h80;

    typedef logic [31:0] word_t;

    // One command per input transaction that carries a byte within the length limit or ends a message.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_end;
        logic       is_err;
        logic       mode;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic first;
        logic mode;
    } comp_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD1,
        ST_PAD2,
        ST_WAIT,
        ST_OUT,
        ST_ERR
    } back_state_t;

    localparam word_t ROUND_K [ROUND_COUNT] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_VALUES [2][8] = '{
        '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
          32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4},
        '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19}
    };

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/sha224_sha256_hash.sv =====
// SHA-256 and SHA-224 hash engine fed one message byte per input transaction. Bytes are
// classified and counted at the input, then travel through a four-entry command queue to a
// block builder and a round unit that runs one round per cycle: a 64-byte block compresses
// in 64 rounds and the chaining add while the next block fills, so a long message is taken
// at about one byte per cycle unless a full block meets a busy round unit. After the padded
// block at the end of a message, plus an extra block when 56 or more bytes of the last block
// are used, eight result transactions carry chaining words 0 to 7 (a SHA-224 user keeps
// words 0 to 6). A message longer than the byte limit gives one result with length_error set.
// Register 0 at address 0 holds hash_mode (1 selects SHA-256, 0 SHA-224, reset 1); a new mode
// applies at once when no byte of the current message has been taken, else from the next one.
module sha224_sha256_hash #(
    parameter int LENGTH_LIMIT_BITS = sha2h_pkg::LENGTH_LIMIT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word,
    output logic        m_length_error
);
    import sha2h_pkg::*;

    localparam int CMD_W = $bits(cmd_t) + LENGTH_LIMIT_BITS;

    logic             hash_mode_reg;
    logic             reg_hit;
    logic             fq_valid, fq_ready;
    logic [CMD_W-1:0] fq_data;
    logic             qb_valid, qb_ready;
    logic [CMD_W-1:0] qb_data;
    logic             comp_busy;
    comp_ctl_t        comp_ctl;
    logic [BLOCK_BITS-1:0] comp_block;
    word_t [7:0]      chain_words;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_HASH_MODE);
    assign prdata  = reg_hit ? {31'b0, hash_mode_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_mode_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            hash_mode_reg <= pwdata[0];
        end
    end

    sha2h_front #(
        .LEN_BITS (LENGTH_LIMIT_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_byte_present   (s_byte_present),
        .s_end_of_message (s_end_of_message),
        .hash_mode        (hash_mode_reg),
        .q_valid          (fq_valid),
        .q_ready          (fq_ready),
        .q_data           (fq_data)
    );

    sha2h_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    sha2h_round u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (comp_ctl),
        .block       (comp_block),
        .busy        (comp_busy),
        .chain_words (chain_words)
    );

    sha2h_back #(
        .LEN_BITS (LENGTH_LIMIT_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (qb_valid),
        .q_ready        (qb_ready),
        .q_data         (qb_data),
        .comp_busy      (comp_busy),
        .comp_ctl       (comp_ctl),
        .comp_block     (comp_block),
        .chain_words    (chain_words),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_digest_word  (m_digest_word),
        .m_word_index   (m_word_index),
        .m_last_word    (m_last_word),
        .m_length_error (m_length_error)
    );

endmodule

// ===== rtl/sha2h_front.sv =====
module sha2h_front #(
    parameter int LEN_BITS = sha2h_pkg::LENGTH_LIMIT_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [7:0]                                s_data_byte,
    input  logic                                      s_byte_present,
    input  logic                                      s_end_of_message,
    input  logic                                      hash_mode,
    output logic                                      q_valid,
    input  logic                                      q_ready,
    output logic [$bits(sha2h_pkg::cmd_t)+LEN_BITS-1:0] q_data
);
    import sha2h_pkg::*;

    logic [LEN_BITS-1:0] count_reg, count_next, count_after;
    logic                ovf_reg, ovf_next, ovf_after;
    logic                msg_mode_reg, msg_mode_next;
    logic                mode_eff;
    logic                take_byte;
    logic                overflow_now;
    logic                accept;
    cmd_t                cmd;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        mode_eff     = (count_reg == '0 && !ovf_reg) ? hash_mode : msg_mode_reg;
        take_byte    = s_byte_present && !ovf_reg && (count_reg != '1);
        overflow_now = s_byte_present && !ovf_reg && (count_reg == '1);
        count_after  = count_reg + LEN_BITS'(take_byte);
        ovf_after    = ovf_reg || overflow_now;

        cmd.data     = s_data_byte;
        cmd.has_byte = take_byte;
        cmd.is_end   = s_end_of_message && !ovf_after;
        cmd.is_err   = s_end_of_message && ovf_after;
        cmd.mode     = mode_eff;

        q_valid = accept && (take_byte || s_end_of_message);
        q_data  = {cmd, count_after};

        count_next    = count_reg;
        ovf_next      = ovf_reg;
        msg_mode_next = msg_mode_reg;
        if (accept) begin
            msg_mode_next = mode_eff;
            if (s_end_of_message) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end else begin
                count_next = count_after;
                ovf_next   = ovf_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            msg_mode_reg <= 1'b1;
        end else begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            msg_mode_reg <= msg_mode_next;
        end
    end

endmodule

// ===== rtl/sha2h_queue.sv =====
module sha2h_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sha2h_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (fill_reg != CNT_W'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/sha2h_round.sv =====
module sha2h_round (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  sha2h_pkg::comp_ctl_t                   ctl,
    input  logic [sha2h_pkg::BLOCK_BITS-1:0]       block,
    output logic                                   busy,
    output sha2h_pkg::word_t [7:0]                 chain_words
);
    import sha2h_pkg::*;

    word_t      sched_reg [16];
    word_t      sched_next [16];
    word_t      var_reg [8];
    word_t      var_next [8];
    word_t      chain_reg [8];
    word_t      chain_next [8];
    word_t      base;
    word_t      w_new, t1, t2, s0, s1, big0, big1, ch, maj;
    logic [5:0] round_reg, round_next;
    logic       run_reg, run_next;
    logic       fin_reg, fin_next;

    assign busy = run_reg || fin_reg;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            chain_words[i] = chain_reg[i];
        end
    end

    always_comb begin
        s0    = rotr(sched_reg[1], 7) ^ rotr(sched_reg[1], 18) ^ (sched_reg[1] >> 3);
        s1    = rotr(sched_reg[14], 17) ^ rotr(sched_reg[14], 19) ^ (sched_reg[14] >> 10);
        w_new = sched_reg[0] + s0 + sched_reg[9] + s1;
        big1  = rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25);
        ch    = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        big0  = rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22);
        maj   = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]);
        t1    = var_reg[7] + big1 + ch + ROUND_K[round_reg] + sched_reg[0];
        t2    = big0 + maj;
        base  = '0;

        sched_next = sched_reg;
        var_next   = var_reg;
        chain_next = chain_reg;
        round_next = round_reg;
        run_next   = run_reg;
        fin_next   = fin_reg;

        if (run_reg) begin
            for (int i = 0; i < 15; i++) begin
                sched_next[i] = sched_reg[i + 1];
            end
            sched_next[15] = w_new;
            var_next[0] = t1 + t2;
            var_next[1] = var_reg[0];
            var_next[2] = var_reg[1];
            var_next[3] = var_reg[2];
            var_next[4] = var_reg[3] + t1;
            var_next[5] = var_reg[4];
            var_next[6] = var_reg[5];
            var_next[7] = var_reg[6];
            round_next  = round_reg + 1'b1;
            if (round_reg == 6'(ROUND_COUNT - 1)) begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end else if (fin_reg) begin
            for (int i = 0; i < 8; i++) begin
                chain_next[i] = chain_reg[i] + var_reg[i];
            end
            fin_next = 1'b0;
        end else if (ctl.start) begin
            for (int i = 0; i < 8; i++) begin
                base          = ctl.first ? INIT_VALUES[ctl.mode][i] : chain_reg[i];
                chain_next[i] = base;
                var_next[i]   = base;
            end
            for (int i = 0; i < 16; i++) begin
                sched_next[i] = block[BLOCK_BITS - 1 - 32 * i -: 32];
            end
            round_next = '0;
            run_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        sched_reg <= sched_next;
        var_reg   <= var_next;
        chain_reg <= chain_next;
        round_reg <= round_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
            fin_reg <= fin_next;
        end
    end

endmodule

// ===== rtl/sha2h_back.sv =====
module sha2h_back #(
    parameter int LEN_BITS = sha2h_pkg::LENGTH_LIMIT_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        q_valid,
    output logic                                        q_ready,
    input  logic [$bits(sha2h_pkg::cmd_t)+LEN_BITS-1:0] q_data,
    input  logic                                        comp_busy,
    output sha2h_pkg::comp_ctl_t                        comp_ctl,
    output logic [sha2h_pkg::BLOCK_BITS-1:0]            comp_block,
    input  sha2h_pkg::word_t [7:0]                      chain_words,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output logic [31:0]                                 m_digest_word,
    output logic [2:0]                                  m_word_index,
    output logic                                        m_last_word,
    output logic                                        m_length_error
);
    import sha2h_pkg::*;

    back_state_t           state_reg, state_next;
    logic [BLOCK_BITS-1:0] block_reg, block_next;
    logic [BLOCK_BITS-1:0] blk_byte, blk_pad;
    logic [LEN_BITS-1:0]   end_count_reg, end_count_next;
    logic [LEN_BITS-1:0]   count;
    logic                  msg_mode_reg, msg_mode_next;
    logic                  first_reg, first_next;
    logic [2:0]            idx_reg, idx_next;
    logic [5:0]            byte_pos, end_pos;
    logic [63:0]           length_bits;
    logic                  need_comp;
    cmd_t                  cmd;

    always_comb begin
        cmd         = cmd_t'(q_data[$bits(cmd_t) + LEN_BITS - 1:LEN_BITS]);
        count       = q_data[LEN_BITS-1:0];
        byte_pos    = 6'(count - LEN_BITS'(1));
        end_pos     = end_count_reg[5:0];
        length_bits = 64'({end_count_reg, 3'b000});

        blk_byte = block_reg;
        blk_byte[{6'd63 - byte_pos, 3'b000} +: 8] = cmd.data;
        blk_pad = block_reg;
        blk_pad[{6'd63 - end_pos, 3'b000} +: 8] = PAD_MARKER;

        need_comp = cmd.has_byte && (byte_pos == 6'd63);

        state_next     = state_reg;
        block_next     = block_reg;
        end_count_next = end_count_reg;
        msg_mode_next  = msg_mode_reg;
        first_next     = first_reg;
        idx_next       = idx_reg;
        q_ready        = 1'b0;
        comp_ctl       = '0;
        comp_block     = block_reg;
        m_valid        = 1'b0;
        m_digest_word  = chain_words[idx_reg];
        m_word_index   = idx_reg;
        m_last_word    = (idx_reg == 3'd7);
        m_length_error = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && !(need_comp && comp_busy)) begin
                    q_ready       = 1'b1;
                    msg_mode_next = cmd.mode;
                    if (cmd.has_byte) begin
                        block_next = blk_byte;
                    end
                    if (need_comp) begin
                        comp_ctl.start = 1'b1;
                        comp_ctl.first = first_reg;
                        comp_ctl.mode  = cmd.mode;
                        comp_block     = blk_byte;
                        block_next     = '0;
                        first_next     = 1'b0;
                    end
                    if (cmd.is_err) begin
                        state_next = ST_ERR;
                    end else if (cmd.is_end) begin
                        end_count_next = count;
                        state_next     = ST_PAD1;
                    end
                end
            end
            ST_PAD1: begin
                if (!comp_busy) begin
                    comp_ctl.start = 1'b1;
                    comp_ctl.first = first_reg;
                    comp_ctl.mode  = msg_mode_reg;
                    first_next     = 1'b0;
                    block_next     = '0;
                    if (end_pos >= 6'd56) begin
                        comp_block = blk_pad;
                        state_next = ST_PAD2;
                    end else begin
                        comp_block = {blk_pad[BLOCK_BITS-1:64], length_bits};
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_PAD2: begin
                if (!comp_busy) begin
                    comp_ctl.start = 1'b1;
                    comp_ctl.first = first_reg;
                    comp_ctl.mode  = msg_mode_reg;
                    comp_block     = {{(BLOCK_BITS - 64){1'b0}}, length_bits};
                    state_next     = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!comp_busy) begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == 3'd7) begin
                        first_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                m_valid        = 1'b1;
                m_digest_word  = '0;
                m_word_index   = '0;
                m_last_word    = 1'b1;
                m_length_error = 1'b1;
                if (m_ready) begin
                    first_next = 1'b1;
                    block_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        end_count_reg <= end_count_next;
        msg_mode_reg  <= msg_mode_next;
        idx_reg       <= idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            block_reg <= '0;
            first_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            block_reg <= block_next;
            first_reg <= first_next;
        end
    end

endmodule
